// ----- rtl/arsp_pkg.sv -----
// Shared widths, constants and the sequencer state type of the spectrum pixel block.
package arsp_pkg;

  localparam int unsigned BIN_W    = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned PEAK_W   = 24;
  localparam int unsigned PIX_W    = 11;
  localparam int unsigned SQ_W     = 2 * BIN_W;
  localparam int unsigned ROOT_W   = SQ_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned GREEN_W  = 6;
  localparam int unsigned NUM_W    = ROOT_W + GREEN_W;
  localparam int unsigned CNT_W    = 5;

  localparam int unsigned MAG_BITS_DEF = 24;

  localparam logic [CFG_W-1:0]  THRESH_RESET = CFG_W'(50);
  localparam logic [PEAK_W-1:0] PEAK_RESET   = PEAK_W'(10);

  // Decay steps applied by a tick.
  localparam logic [PEAK_W-1:0] DECAY_HI_LIM  = PEAK_W'(1000);
  localparam logic [PEAK_W-1:0] DECAY_HI_STEP = PEAK_W'(200);
  localparam logic [PEAK_W-1:0] DECAY_MD_LIM  = PEAK_W'(500);
  localparam logic [PEAK_W-1:0] DECAY_MD_STEP = PEAK_W'(100);
  localparam logic [PEAK_W-1:0] DECAY_LO_LIM  = PEAK_W'(200);
  localparam logic [PEAK_W-1:0] DECAY_LO_STEP = PEAK_W'(20);
  localparam logic [PEAK_W-1:0] DECAY_MN_LIM  = PEAK_W'(4);
  localparam logic [PEAK_W-1:0] DECAY_MN_STEP = PEAK_W'(2);

  localparam logic FUNC_BIN  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SQRT,
    ST_POST,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/arsp_if.sv -----
// Valid/ready channel interfaces for bin requests and pixel results.
interface arsp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    func;
  logic signed [arsp_pkg::BIN_W-1:0]       bin_real;
  logic signed [arsp_pkg::BIN_W-1:0]       bin_imag;

  modport source (output valid, output func, output bin_real, output bin_imag, input ready);
  modport sink   (input valid, input func, input bin_real, input bin_imag, output ready);
endinterface

interface arsp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [arsp_pkg::PIX_W-1:0]              pixel_color;
  logic [arsp_pkg::PEAK_W-1:0]             peak_level;

  modport source (output valid, output pixel_color, output peak_level, input ready);
  modport sink   (input valid, input pixel_color, input peak_level, output ready);
endinterface

// ----- rtl/auto_range_spectrum_pixel_core.sv -----
// A bin request runs through every sequencer step below; a tick only applies the peak decay.
// The sequencer squares the real and imaginary parts on one shared 24x24 multiplier, then
// runs the bit-serial square root, the clamp step, restoring division and the output load.
// One request at a time; the next is taken only after the output load, which waits on ready.
// Reset (rst_ni low, asynchronous): threshold 50, peak reference 10, no result pending.
// Top level of the auto-ranging spectrum pixel block.
module auto_range_spectrum_pixel_core #(
  parameter int unsigned MAG_BITS = arsp_pkg::MAG_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [arsp_pkg::CFG_W-1:0] cfg_wdata_i,
  arsp_in_if.sink                    bin_i,
  arsp_out_if.source                 pix_o
);
  import arsp_pkg::*;

  localparam int unsigned CMP_W = (MAG_BITS > ROOT_W) ? MAG_BITS : ROOT_W;
  localparam logic [CMP_W-1:0] MagMax = CMP_W'((64'd1 << MAG_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] SqrtLast = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DivFirst = CNT_W'(GREEN_W - 1);

  state_e state_q, state_d;

  logic [CFG_W-1:0]            thr_q;
  logic [PEAK_W-1:0]           peak_q, peak_d;
  logic signed [BIN_W-1:0]     re_q, im_q;
  logic [SQ_W-1:0]             acc_q;
  logic [REM_W-1:0]            rem_q;
  logic [ROOT_W-1:0]           root_q;
  logic [NUM_W-1:0]            num_q;
  logic [GREEN_W-1:0]          quo_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        out_valid_q;
  logic [PIX_W-1:0]            out_pix_q;
  logic [PEAK_W-1:0]           out_peak_q;

  logic                        in_take;
  logic                        out_load;

  // Shared multiplier: squares the real part, then the imaginary part.
  logic signed [BIN_W-1:0]     mul_op;
  logic signed [SQ_W-1:0]      mul_prod;

  // Square root step.
  logic [REM_W-1:0]            rem_sh;
  logic [REM_W-1:0]            trial;
  logic                        root_bit;

  // Clamp, threshold and peak update.
  logic [CMP_W-1:0]            root_ext;
  logic [CMP_W-1:0]            mag_clamp;
  logic [PEAK_W-1:0]           mag_thr;

  // Division step.
  logic [NUM_W-1:0]            dvs;
  logic                        quo_bit;

  // Decay.
  logic [PEAK_W-1:0]           dec_a;

  assign mul_op   = (state_q == ST_SQ_RE) ? re_q : im_q;
  assign mul_prod = SQ_W'(mul_op) * SQ_W'(mul_op);

  assign rem_sh   = {rem_q[REM_W-3:0], acc_q[SQ_W-1 -: 2]};
  assign trial    = REM_W'({root_q, 2'b01});
  assign root_bit = (rem_sh >= trial);

  assign root_ext  = CMP_W'(root_q);
  assign mag_clamp = (root_ext > MagMax) ? MagMax : root_ext;
  assign mag_thr   = (mag_clamp[PEAK_W-1:0] < thr_q) ? '0 : mag_clamp[PEAK_W-1:0];

  assign dvs     = NUM_W'(peak_q) << cnt_q[2:0];
  assign quo_bit = (num_q >= dvs);

  always_comb begin
    dec_a = peak_q;
    if (peak_q > DECAY_HI_LIM) begin
      dec_a = peak_q - DECAY_HI_STEP;
    end
    peak_d = dec_a;
    if (dec_a > DECAY_MD_LIM) begin
      peak_d = dec_a - DECAY_MD_STEP;
    end else if (dec_a > DECAY_LO_LIM) begin
      peak_d = dec_a - DECAY_LO_STEP;
    end else if (dec_a > DECAY_MN_LIM) begin
      peak_d = dec_a - DECAY_MN_STEP;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (bin_i.valid) begin
          state_d = (bin_i.func == FUNC_TICK) ? ST_TICK : ST_SQ_RE;
        end
      end
      ST_TICK:  state_d = ST_IDLE;
      ST_SQ_RE: state_d = ST_SQ_IM;
      ST_SQ_IM: state_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == SqrtLast) begin
          state_d = ST_POST;
        end
      end
      ST_POST:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || pix_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_take  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_take  = bin_i.valid;
      ST_DONE: out_load = !out_valid_q || pix_o.ready;
      default: begin
        in_take  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign bin_i.ready     = (state_q == ST_IDLE);
  assign pix_o.valid     = out_valid_q;
  assign pix_o.pixel_color = out_pix_q;
  assign pix_o.peak_level  = out_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESH_RESET;
      peak_q      <= PEAK_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (state_q == ST_TICK) begin
        peak_q <= peak_d;
      end else if (state_q == ST_POST && mag_thr > peak_q) begin
        peak_q <= mag_thr;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_SQ_IM: cnt_q <= '0;
        ST_SQRT:  cnt_q <= cnt_q + CNT_W'(1);
        ST_POST:  cnt_q <= DivFirst;
        ST_DIV:   cnt_q <= cnt_q - CNT_W'(1);
        default:  cnt_q <= cnt_q;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      re_q <= bin_i.bin_real;
      im_q <= bin_i.bin_imag;
    end
    unique case (state_q)
      ST_SQ_RE: acc_q <= SQ_W'(unsigned'(mul_prod));
      ST_SQ_IM: begin
        acc_q  <= acc_q + SQ_W'(unsigned'(mul_prod));
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        acc_q  <= acc_q << 2;
        rem_q  <= root_bit ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[ROOT_W-2:0], root_bit};
      end
      ST_POST: begin
        // Numerator 63 * mag, formed as 64 * mag - mag.
        num_q <= (NUM_W'(mag_thr) << GREEN_W) - NUM_W'(mag_thr);
        quo_q <= '0;
      end
      ST_DIV: begin
        if (quo_bit) begin
          num_q <= num_q - dvs;
        end
        quo_q <= {quo_q[GREEN_W-2:0], quo_bit};
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
    if (out_load) begin
      out_pix_q  <= (peak_q == '0) ? '0 : PIX_W'({quo_q, 5'b00000});
      out_peak_q <= peak_q;
    end
  end

endmodule
